// ----- hdl/tmbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmbe_pkg
// Shared types and constants for the thruster mixer with button edges.
// ----------------------------------------------------------------------------
package tmbe_pkg;

  // Field counts fixed by the payload layout
  localparam int MAX_CHANNELS = 4;
  localparam int MAX_MOTORS   = 8;

  // Counts actually mixed (1..MAX_CHANNELS, 1..MAX_MOTORS)
  localparam int NUM_CHANNELS = 4;
  localparam int NUM_MOTORS   = 8;

  localparam int CH_W    = 16;
  localparam int ROW_W   = 32;
  localparam int HALF_W  = ROW_W / 2;
  localparam int MAG_W   = 8;
  localparam int SPEED_W = 8;
  localparam int LEVEL_W = 8;
  localparam int BTN_W   = 3;

  // Worst case |sum| is NUM_CHANNELS * 2 * 255, plus a sign bit
  localparam int SUM_W = $clog2(NUM_CHANNELS * 2 * 255 + 1) + 1;

  localparam logic [CH_W-1:0]  CENTRE = 16'd256;
  localparam logic [MAG_W-1:0] SPAN   = 8'd255;
  // Stick value standing in for a channel when every channel reads zero
  localparam logic [CH_W-1:0]  IDLE_CH = 16'd255;

  // Button bit positions
  localparam int BTN_BRIGHTER = 0;
  localparam int BTN_REBOOT   = 1;
  localparam int BTN_DIMMER   = 2;

  // Configuration register map
  typedef enum logic [2:0] {
    CFG_CH0_ROWS    = 3'd0,
    CFG_CH1_ROWS    = 3'd1,
    CFG_CH2_ROWS    = 3'd2,
    CFG_CH3_ROWS    = 3'd3,
    CFG_DEADBAND    = 3'd4,
    CFG_BRIGHT_STEP = 3'd5,
    CFG_BRIGHT_MAX  = 3'd6
  } cfg_idx_e;

  localparam logic [MAX_CHANNELS-1:0][ROW_W-1:0] ROWS_RST = {
    32'd3211283, 32'd872422400, 32'd4456652, 32'd50331904
  };
  localparam logic [7:0] DEADBAND_RST    = 8'd20;
  localparam logic [7:0] BRIGHT_STEP_RST = 8'd16;
  localparam logic [7:0] BRIGHT_MAX_RST  = 8'd240;

  typedef struct packed {
    logic [CH_W-1:0]  channel_0;
    logic [CH_W-1:0]  channel_1;
    logic [CH_W-1:0]  channel_2;
    logic [CH_W-1:0]  channel_3;
    logic [BTN_W-1:0] button_bits;
    logic             buttons_present;
  } tmbe_in_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_0;
    logic [SPEED_W-1:0] speed_1;
    logic [SPEED_W-1:0] speed_2;
    logic [SPEED_W-1:0] speed_3;
    logic [SPEED_W-1:0] speed_4;
    logic [SPEED_W-1:0] speed_5;
    logic [SPEED_W-1:0] speed_6;
    logic [SPEED_W-1:0] speed_7;
    logic [MAX_MOTORS-1:0] direction_mask;
    logic [LEVEL_W-1:0] brightness;
    logic               brightness_changed;
    logic               reboot_request;
  } tmbe_out_t;

  // Button unit result for one request
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               changed;
    logic               reboot;
  } tmbe_btn_t;

endpackage

// ----- hdl/tmbe_mixer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmbe_mixer
// Combinational stick-to-motor mix: clamp, row select, sum, deadband.
// ----------------------------------------------------------------------------
module tmbe_mixer (
  input  tmbe_pkg::tmbe_in_t                                              item_i,
  input  logic [tmbe_pkg::MAX_CHANNELS-1:0][tmbe_pkg::ROW_W-1:0]          rows_i,
  input  logic [tmbe_pkg::SPEED_W-1:0]                                    deadband_i,
  output logic [tmbe_pkg::MAX_MOTORS-1:0][tmbe_pkg::SPEED_W-1:0]          speed_o,
  output logic [tmbe_pkg::MAX_MOTORS-1:0]                                 dir_o
);
  import tmbe_pkg::*;

  logic [CH_W-1:0]  raw [MAX_CHANNELS];
  logic             all_zero;
  logic [MAG_W-1:0] mag [MAX_CHANNELS];
  logic             neg [MAX_CHANNELS];

  assign raw[0] = item_i.channel_0;
  assign raw[1] = item_i.channel_1;
  assign raw[2] = item_i.channel_2;
  assign raw[3] = item_i.channel_3;

  always_comb begin
    all_zero = 1'b1;
    for (int n = 0; n < NUM_CHANNELS; n++) begin
      if (raw[n] != '0) begin
        all_zero = 1'b0;
      end
    end
  end

  // Offset from centre, clamped to +/-SPAN, as sign and magnitude.
  // At centre the negative row is picked, but the magnitude is zero.
  always_comb begin
    logic [CH_W-1:0] val;
    for (int n = 0; n < MAX_CHANNELS; n++) begin
      val = all_zero ? IDLE_CH : raw[n];
      if (val >= CENTRE + CH_W'(SPAN)) begin
        mag[n] = SPAN;
        neg[n] = 1'b0;
      end else if (val > CENTRE) begin
        mag[n] = MAG_W'(val - CENTRE);
        neg[n] = 1'b0;
      end else if (val == '0) begin
        mag[n] = SPAN;
        neg[n] = 1'b1;
      end else begin
        mag[n] = MAG_W'(CENTRE - val);
        neg[n] = 1'b1;
      end
    end
  end

  always_comb begin
    logic [HALF_W-1:0]       half;
    logic signed [1:0]       coef;
    logic signed [MAG_W+2:0] term;
    logic signed [SUM_W-1:0] acc;
    logic [SUM_W-1:0]        abs_v;
    logic [SPEED_W-1:0]      spd;
    for (int k = 0; k < MAX_MOTORS; k++) begin
      acc = '0;
      for (int n = 0; n < NUM_CHANNELS; n++) begin
        half = neg[n] ? rows_i[n][ROW_W-1:HALF_W] : rows_i[n][HALF_W-1:0];
        coef = $signed(half[2*k +: 2]);
        term = (MAG_W+3)'(coef) * (MAG_W+3)'($signed({1'b0, mag[n]}));
        acc  = acc + SUM_W'(term);
      end
      abs_v = acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
      spd   = (abs_v > SUM_W'(SPAN)) ? SPAN : abs_v[SPEED_W-1:0];
      if (spd < deadband_i) begin
        spd = '0;
      end
      if (k < NUM_MOTORS) begin
        speed_o[k] = spd;
        dir_o[k]   = !acc[SUM_W-1];
      end else begin
        speed_o[k] = '0;
        dir_o[k]   = 1'b0;
      end
    end
  end

endmodule

// ----- hdl/tmbe_buttons.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmbe_buttons
// Button edge detect, saturating brightness level and reboot pulse.
// ----------------------------------------------------------------------------
module tmbe_buttons (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [tmbe_pkg::BTN_W-1:0]     bits_i,
  input  logic                           present_i,
  input  logic [tmbe_pkg::LEVEL_W-1:0]   step_i,
  input  logic [tmbe_pkg::LEVEL_W-1:0]   max_i,
  output tmbe_pkg::tmbe_btn_t            btn_o
);
  import tmbe_pkg::*;

  logic [LEVEL_W-1:0] level_q, level_d;
  logic [BTN_W-1:0]   prev_q, prev_d;
  logic [BTN_W-1:0]   rise;
  logic [LEVEL_W-1:0] lvl_up;

  // level +/- step, then clip to max first, to zero second
  function automatic logic [LEVEL_W-1:0] step_level(
    input logic [LEVEL_W-1:0] level,
    input logic [LEVEL_W-1:0] step,
    input logic [LEVEL_W-1:0] lim,
    input logic               down
  );
    logic signed [LEVEL_W+1:0] v;
    logic [LEVEL_W-1:0]        r;
    v = down ? $signed({2'b00, level}) - $signed({2'b00, step})
             : $signed({2'b00, level}) + $signed({2'b00, step});
    if (v >= $signed({2'b00, lim})) begin
      r = lim;
    end else if (v <= 0) begin
      r = '0;
    end else begin
      r = v[LEVEL_W-1:0];
    end
    return r;
  endfunction

  assign rise   = present_i ? (bits_i & ~prev_q) : '0;
  assign lvl_up = rise[BTN_BRIGHTER] ? step_level(level_q, step_i, max_i, 1'b0) : level_q;

  always_comb begin
    level_d = rise[BTN_DIMMER] ? step_level(lvl_up, step_i, max_i, 1'b1) : lvl_up;
    prev_d  = present_i ? bits_i : prev_q;
    btn_o.level   = level_d;
    btn_o.changed = rise[BTN_BRIGHTER] | rise[BTN_DIMMER];
    btn_o.reboot  = rise[BTN_REBOOT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      prev_q  <= '0;
    end else if (en_i) begin
      level_q <= level_d;
      prev_q  <= prev_d;
    end
  end

endmodule

// ----- hdl/thruster_mixer_with_button_edges.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thruster_mixer_with_button_edges
// Eight-motor thruster mixer with button edge handling and brightness level.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one result per request, in order.
// The request lands in an input register, and a single
// combinational pass (channel clamp, coefficient row pick, four-term motor
// sums, speed clamp and deadband, plus the brightness step) feeds the result
// register. Throughput is one request per cycle as long as the result side
// takes results; a stalled result register holds, and the input register
// still takes one more request behind it. Brightness and button history
// update when a request moves into the result register, so their order
// follows the request order. Configuration writes are accepted every cycle
// (cfg_ready_o is always high) and are meant to land only while no request
// is in flight; indexes past the last register are dropped.
// ----------------------------------------------------------------------------
module thruster_mixer_with_button_edges (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tmbe_pkg::tmbe_in_t    in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tmbe_pkg::tmbe_out_t   out_data_o,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [tmbe_pkg::ROW_W-1:0] cfg_data_i
);
  import tmbe_pkg::*;

  // Configuration registers
  logic [MAX_CHANNELS-1:0][ROW_W-1:0] rows_q;
  logic [SPEED_W-1:0]                 deadband_q;
  logic [LEVEL_W-1:0]                 step_q;
  logic [LEVEL_W-1:0]                 max_q;

  // Pipeline registers
  logic      in_valid_q;
  tmbe_in_t  in_q;
  logic      out_valid_q;
  tmbe_out_t out_q, out_d;
  logic      advance;

  logic [MAX_MOTORS-1:0][SPEED_W-1:0] speed;
  logic [MAX_MOTORS-1:0]              dir;
  tmbe_btn_t                          btn;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     <= ROWS_RST;
      deadband_q <= DEADBAND_RST;
      step_q     <= BRIGHT_STEP_RST;
      max_q      <= BRIGHT_MAX_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CH0_ROWS:    rows_q[0]  <= cfg_data_i;
        CFG_CH1_ROWS:    rows_q[1]  <= cfg_data_i;
        CFG_CH2_ROWS:    rows_q[2]  <= cfg_data_i;
        CFG_CH3_ROWS:    rows_q[3]  <= cfg_data_i;
        CFG_DEADBAND:    deadband_q <= cfg_data_i[SPEED_W-1:0];
        CFG_BRIGHT_STEP: step_q     <= cfg_data_i[LEVEL_W-1:0];
        CFG_BRIGHT_MAX:  max_q      <= cfg_data_i[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input stage moves on whenever the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  tmbe_mixer u_mixer (
    .item_i     (in_q),
    .rows_i     (rows_q),
    .deadband_i (deadband_q),
    .speed_o    (speed),
    .dir_o      (dir)
  );

  // Level and button history commit only when the request moves on
  tmbe_buttons u_buttons (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .bits_i    (in_q.button_bits),
    .present_i (in_q.buttons_present),
    .step_i    (step_q),
    .max_i     (max_q),
    .btn_o     (btn)
  );

  always_comb begin
    out_d.speed_0            = speed[0];
    out_d.speed_1            = speed[1];
    out_d.speed_2            = speed[2];
    out_d.speed_3            = speed[3];
    out_d.speed_4            = speed[4];
    out_d.speed_5            = speed[5];
    out_d.speed_6            = speed[6];
    out_d.speed_7            = speed[7];
    out_d.direction_mask     = dir;
    out_d.brightness         = btn.level;
    out_d.brightness_changed = btn.changed;
    out_d.reboot_request     = btn.reboot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A stepped level never lands above the limit
  a_level_within_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.brightness_changed |-> out_data_o.brightness <= max_q)
    else $error("brightness above limit after a step");

  // A nonzero speed_0 has cleared the deadband
  a_speed_deadband: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.speed_0 != '0 |-> out_data_o.speed_0 >= deadband_q)
    else $error("speed inside deadband");

  // Both stages full and stalled: no new request may enter
  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request accepted into full pipeline");

  // A result held under stall keeps its payload
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

// ----- sim/tb_thruster_mixer_with_button_edges.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thruster_mixer_with_button_edges
// Self-checking bench for the thruster mixer with button edges.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the mixing coefficients, deadband,
// brightness settings, light level and button history. It predicts one
// result for every accepted request and compares each returned result,
// field by field, with the oldest prediction. A short directed list comes
// first, then six configuration phases of random requests under changing
// idle patterns, two long result hold-offs and two sender pauses.
// ----------------------------------------------------------------------------
module tb_thruster_mixer_with_button_edges;
  import tmbe_pkg::*;

  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          HOLD_CYCLES     = 60;
  localparam int          SETTLE_CYCLES   = 4;
  localparam int          RANDOM_PER_SET  = 75;
  localparam int          NUM_SETS        = 6;
  // Index past the register map; the block drops writes to it
  localparam logic [2:0]  CFG_PAST_LAST   = 3'd7;

  // --------------------------------------------------------------------------
  // Scoreboard: mixer prediction plus in-order result checking
  // --------------------------------------------------------------------------
  class mixer_scoreboard;
    logic [ROW_W-1:0]   coef_rows [MAX_CHANNELS];
    logic [7:0]         deadband;
    logic [7:0]         level_step;
    logic [7:0]         level_max;
    logic [LEVEL_W-1:0] light_level;
    logic [BTN_W-1:0]   prev_btn;
    tmbe_out_t          predicted_q[$];
    int                 mismatches;

    function new();
      for (int n = 0; n < MAX_CHANNELS; n++) coef_rows[n] = ROWS_RST[n];
      deadband    = DEADBAND_RST;
      level_step  = BRIGHT_STEP_RST;
      level_max   = BRIGHT_MAX_RST;
      light_level = '0;
      prev_btn    = '0;
      mismatches  = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [ROW_W-1:0] data);
      case (idx)
        CFG_CH0_ROWS, CFG_CH1_ROWS, CFG_CH2_ROWS, CFG_CH3_ROWS: coef_rows[idx[1:0]] = data;
        CFG_DEADBAND:    deadband   = data[7:0];
        CFG_BRIGHT_STEP: level_step = data[7:0];
        CFG_BRIGHT_MAX:  level_max  = data[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return predicted_q.size();
    endfunction

    // Saturating brightness step: hits the max first, then the floor
    function logic [LEVEL_W-1:0] stepped_level(int base, int delta);
      int v;
      v = base + delta;
      if (v >= int'(level_max)) v = int'(level_max);
      else if (v <= 0) v = 0;
      return v[LEVEL_W-1:0];
    endfunction

    function void note_request(tmbe_in_t req);
      int               chv [MAX_CHANNELS];
      int               motor_sum [MAX_MOTORS];
      logic [7:0]       spd [MAX_MOTORS];
      logic [HALF_W-1:0] half;
      logic [1:0]       code;
      logic [BTN_W-1:0] rise;
      bit               all_zero;
      bit               neg;
      int               v, mag, coef, a;
      tmbe_out_t        r;

      chv[0] = int'(req.channel_0);
      chv[1] = int'(req.channel_1);
      chv[2] = int'(req.channel_2);
      chv[3] = int'(req.channel_3);
      all_zero = 1;
      for (int n = 0; n < NUM_CHANNELS; n++) if (chv[n] != 0) all_zero = 0;
      // sticks all at zero means no link yet: treat as just below centre
      if (all_zero)
        for (int n = 0; n < NUM_CHANNELS; n++) chv[n] = int'(IDLE_CH);

      r = '0;
      for (int k = 0; k < MAX_MOTORS; k++) motor_sum[k] = 0;
      for (int n = 0; n < NUM_CHANNELS; n++) begin
        v = chv[n] - int'(CENTRE);
        if (v > int'(SPAN)) v = int'(SPAN);
        else if (v < -int'(SPAN)) v = -int'(SPAN);
        neg  = !(v > 0);
        mag  = (v < 0) ? -v : v;
        half = neg ? coef_rows[n][ROW_W-1:HALF_W] : coef_rows[n][HALF_W-1:0];
        for (int k = 0; k < NUM_MOTORS; k++) begin
          code = half[2*k +: 2];
          coef = code[1] ? int'(code) - 4 : int'(code);
          motor_sum[k] += coef * mag;
        end
      end

      for (int k = 0; k < MAX_MOTORS; k++) begin
        spd[k] = '0;
        if (k < NUM_MOTORS) begin
          a = (motor_sum[k] < 0) ? -motor_sum[k] : motor_sum[k];
          if (motor_sum[k] >= 0) r.direction_mask[k] = 1'b1;
          if (a > int'(SPAN)) a = int'(SPAN);
          if (a < int'(deadband)) a = 0;
          spd[k] = a[7:0];
        end
      end
      r.speed_0 = spd[0]; r.speed_1 = spd[1]; r.speed_2 = spd[2]; r.speed_3 = spd[3];
      r.speed_4 = spd[4]; r.speed_5 = spd[5]; r.speed_6 = spd[6]; r.speed_7 = spd[7];

      // Button word only counts when flagged present; history kept otherwise
      if (req.buttons_present) begin
        rise = req.button_bits & ~prev_btn;
        if (rise[BTN_BRIGHTER]) begin
          light_level = stepped_level(int'(light_level), int'(level_step));
          r.brightness_changed = 1'b1;
        end
        if (rise[BTN_DIMMER]) begin
          light_level = stepped_level(int'(light_level), -int'(level_step));
          r.brightness_changed = 1'b1;
        end
        r.reboot_request = rise[BTN_REBOOT];
        prev_btn = req.button_bits;
      end
      r.brightness = light_level;
      predicted_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      mismatches++;
    endtask

    task check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want)
        report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    task check_result(tmbe_out_t got);
      tmbe_out_t want;
      if (predicted_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = predicted_q.pop_front();
        check_field("speed_0", want.speed_0, got.speed_0);
        check_field("speed_1", want.speed_1, got.speed_1);
        check_field("speed_2", want.speed_2, got.speed_2);
        check_field("speed_3", want.speed_3, got.speed_3);
        check_field("speed_4", want.speed_4, got.speed_4);
        check_field("speed_5", want.speed_5, got.speed_5);
        check_field("speed_6", want.speed_6, got.speed_6);
        check_field("speed_7", want.speed_7, got.speed_7);
        check_field("direction_mask", want.direction_mask, got.direction_mask);
        check_field("brightness", want.brightness, got.brightness);
        check_field("brightness_changed", 8'(want.brightness_changed),
                    8'(got.brightness_changed));
        check_field("reboot_request", 8'(want.reboot_request), 8'(got.reboot_request));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block hookup
  // --------------------------------------------------------------------------
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready_o;
  tmbe_in_t          in_data = '0;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  tmbe_out_t         out_data_o;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index = '0;
  logic [ROW_W-1:0]  cfg_data = '0;

  always #2 clk_i = ~clk_i;

  thruster_mixer_with_button_edges dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  mixer_scoreboard sb = new();

  // Idle percentages for the two sides, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Set by the stimulus to start one long result hold-off
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int cycle_count    = 0;

  // --------------------------------------------------------------------------
  // Monitors: every handshake is sampled at the clock edge it happens on.
  // All handshake signals are driven with nonblocking updates, so these see the
  // values that were stable before the edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready_o) sb.note_request(in_data);
    if (rst_ni && cfg_valid && cfg_ready_o) sb.set_register(cfg_index, cfg_data);
    if (rst_ni && out_valid_o && out_ready) sb.check_result(out_data_o);
  end

  // Result side: random stalls, or a long hold-off counted here so the
  // sender keeps pushing and the block backs up into its input
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $time, cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one request, after a random gap; valid stays up for a following
  // request so it is never dropped and raised in the same step.
  task send_request(tmbe_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending and wait for every predicted result to come back
  task wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task write_register(logic [2:0] idx, logic [ROW_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Only called with the block drained and given time to settle
  task apply_settings(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                      logic [ROW_W-1:0] r2, logic [ROW_W-1:0] r3,
                      logic [7:0] db, logic [7:0] st, logic [7:0] mx);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_register(CFG_CH0_ROWS, r0);
    write_register(CFG_CH1_ROWS, r1);
    write_register(CFG_CH2_ROWS, r2);
    write_register(CFG_CH3_ROWS, r3);
    write_register(CFG_DEADBAND, {24'd0, db});
    write_register(CFG_BRIGHT_STEP, {24'd0, st});
    write_register(CFG_BRIGHT_MAX, {24'd0, mx});
    // must be ignored by the block
    write_register(CFG_PAST_LAST, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  function tmbe_in_t mk(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                        logic [15:0] c3, logic [2:0] btn, logic present);
    tmbe_in_t r;
    r.channel_0       = c0;
    r.channel_1       = c1;
    r.channel_2       = c2;
    r.channel_3       = c3;
    r.button_bits     = btn;
    r.buttons_present = present;
    return r;
  endfunction

  // Mostly around the stick range, with full-width values and clamp corners
  function logic [15:0] pick_channel();
    logic [15:0] corners [8];
    corners = '{16'd0, 16'd1, 16'd255, 16'd256, 16'd257, 16'd511, 16'd512, 16'hFFFF};
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1, 2:    return corners[$urandom_range(7)];
      default: return 16'($urandom_range(520));
    endcase
  endfunction

  function tmbe_in_t make_request();
    tmbe_in_t r;
    r.channel_0 = pick_channel();
    r.channel_1 = pick_channel();
    r.channel_2 = pick_channel();
    r.channel_3 = pick_channel();
    // no-link case: all sticks read zero
    if ($urandom_range(19) == 0) begin
      r.channel_0 = '0; r.channel_1 = '0; r.channel_2 = '0; r.channel_3 = '0;
    end
    r.button_bits     = 3'($urandom_range(7));
    r.buttons_present = ($urandom_range(9) != 0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under reset settings; light receiver stalls
    send_idle_pct  = 10;
    recv_stall_pct = 30;
    send_request(mk(16'd0, 16'd0, 16'd0, 16'd0, 3'd0, 1'b0));          // no-link stand-in
    send_request(mk(16'd256, 16'd256, 16'd256, 16'd256, 3'd0, 1'b1));  // all centred
    send_request(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd1, 1'b1)); // brighter
    send_request(mk(16'd0, 16'd1, 16'd255, 16'd257, 3'd1, 1'b1));      // held, no edge
    send_request(mk(16'd511, 16'd512, 16'd0, 16'hFFFF, 3'd0, 1'b1));   // release
    send_request(mk(16'd1, 16'd0, 16'd0, 16'd0, 3'd4, 1'b1));          // dimmer
    send_request(mk(16'd0, 16'd0, 16'd0, 16'd1, 3'd2, 1'b1));          // reboot edge
    send_request(mk(16'd300, 16'd200, 16'd400, 16'd100, 3'd7, 1'b0));  // buttons absent
    send_request(mk(16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF, 3'd7, 1'b1)); // both steps
    send_request(mk(16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 3'd0, 1'b1));
    send_request(mk(16'd260, 16'd250, 16'd384, 16'd128, 3'd7, 1'b1));  // every button rises
    send_request(mk(16'd256, 16'd0, 16'd256, 16'd0, 3'd5, 1'b0));
    send_request(mk(16'd257, 16'd255, 16'd256, 16'd256, 3'd0, 1'b1));
    send_request(mk(16'd0, 16'd0, 16'd0, 16'd0, 3'd1, 1'b1));

    for (int phase = 0; phase < NUM_SETS; phase++) begin
      // sender mostly busy / receiver mostly stalled, then swapped, then free
      case (phase / 2)
        0:       begin send_idle_pct = 10; recv_stall_pct = 79; end
        1:       begin send_idle_pct = 79; recv_stall_pct = 10; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      case (phase)
        0: apply_settings($urandom, $urandom, $urandom, $urandom, 8'd0, 8'd255, 8'd255);
        1: apply_settings('1, '1, '1, '1, 8'd255, 8'd0, 8'd0);
        2: apply_settings(32'hAAAA5555, '0, $urandom, 32'hFFFF0000, 8'd1, 8'd1, 8'd1);
        3: apply_settings($urandom, $urandom, $urandom, $urandom, 8'($urandom_range(40)),
                          8'($urandom_range(1, 80)), 8'($urandom_range(100, 255)));
        4: apply_settings(ROWS_RST[0], ROWS_RST[1], ROWS_RST[2], ROWS_RST[3],
                          DEADBAND_RST, BRIGHT_STEP_RST, BRIGHT_MAX_RST);
        default: apply_settings($urandom, $urandom, $urandom, $urandom,
                                8'($urandom_range(255)), 8'($urandom_range(255)),
                                8'($urandom_range(255)));
      endcase
      for (int i = 0; i < RANDOM_PER_SET; i++) begin
        // long result hold-off while requests keep coming
        if ((phase == 2 && i == 30) || (phase == 4 && i == 20)) hold_req = 1'b1;
        // sender pause until everything in flight has returned
        if ((phase == 3 || phase == 5) && i == 40) wait_for_results();
        send_request(make_request());
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
